@@ hw/rtl/sha256_pkg.sv @@
package sha256_pkg;

  // One input transaction: a message byte and its flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_t;

  // One result transaction: 64 bits of the digest
  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_t;

  localparam int SCHED_DEPTH = 16;
  localparam int WORD_W      = 32;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Initial chaining value
  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  // Round constants
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  function automatic logic [31:0] ror32(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage

@@ hw/rtl/sha256_ram.sv @@
module sha256_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/sha256_message_digest.sv @@
// Streaming SHA-256 digest over a byte stream.
// A byte that does not complete a block is taken while idle; a full block adds a
// compression of 64 rounds plus a final chaining update (3 schedule RAM reads per round).
// End of message: 1 cycle per pad byte (up to 64), 2 length writes, one or two
// compressions, then four result transactions, one per cycle when not stalled.
// Reset is synchronous (rst_n low); the schedule RAM is not cleared.
module sha256_message_digest
  import sha256_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // Controller states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PAD  = 3'd1;
  localparam logic [2:0] S_LEN0 = 3'd2;
  localparam logic [2:0] S_LEN1 = 3'd3;
  localparam logic [2:0] S_COMP = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // Round phases
  localparam logic [2:0] PH_A   = 3'd0;
  localparam logic [2:0] PH_B   = 3'd1;
  localparam logic [2:0] PH_C   = 3'd2;
  localparam logic [2:0] PH_W   = 3'd3;
  localparam logic [2:0] PH_RND = 3'd4;

  localparam int AW = $clog2(SCHED_DEPTH);
  localparam logic [AW-1:0] LEN_HI_ADDR = AW'(14);
  localparam logic [AW-1:0] LEN_LO_ADDR = AW'(15);
  localparam logic [5:0]    LEN_POS     = 6'd56;

  logic [2:0]  state_r, state_nxt;
  logic [2:0]  ret_r, ret_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] len_r, len_nxt;
  logic [23:0] asm_r, asm_nxt;
  logic        pad_first_r, pad_first_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] chain_r [8];
  logic [31:0] chain_nxt [8];
  logic [31:0] rv_r [8];
  logic [31:0] rv_nxt [8];
  logic [31:0] wa_r, wa_nxt, wb_r, wb_nxt, wr_r, wr_nxt;
  logic [31:0] wm1_r, wm1_nxt, wm2_r, wm2_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic        place_en;
  logic [7:0]  place_val;
  logic        place_wrap;
  logic        in_acc;

  logic [31:0] g0, g1, sched_sum;
  logic [31:0] s1, chv, t1, s0, mj, t2;

  sha256_ram #(.WIDTH(WORD_W), .DEPTH(SCHED_DEPTH)) u_sched (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == S_OUT);

  // Digest word from the chaining value; stable while stalled
  assign out_data.digest_word = {chain_r[{idx_r, 1'b0}], chain_r[{idx_r, 1'b1}]};
  assign out_data.word_index  = idx_r;
  assign out_data.last_word   = (idx_r == 2'd3);

  // Message schedule expansion
  assign g0 = ror32(wb_r, 7) ^ ror32(wb_r, 18) ^ (wb_r >> 3);
  assign g1 = ror32(wm2_r, 17) ^ ror32(wm2_r, 19) ^ (wm2_r >> 10);
  assign sched_sum = wa_r + g0 + ram_rdata + g1;

  // Round function
  assign s1  = ror32(rv_r[4], 6) ^ ror32(rv_r[4], 11) ^ ror32(rv_r[4], 25);
  assign chv = (rv_r[4] & rv_r[5]) ^ (~rv_r[4] & rv_r[6]);
  assign t1  = rv_r[7] + s1 + chv + ROUND_K[rnd_r] + wr_r;
  assign s0  = ror32(rv_r[0], 2) ^ ror32(rv_r[0], 13) ^ ror32(rv_r[0], 22);
  assign mj  = (rv_r[0] & rv_r[1]) ^ (rv_r[0] & rv_r[2]) ^ (rv_r[1] & rv_r[2]);
  assign t2  = s0 + mj;

  // Schedule read address follows the round phase
  always_comb begin
    unique case (ph_r)
      PH_B:    ram_raddr = rnd_r[AW-1:0] + AW'(1);
      PH_C:    ram_raddr = rnd_r[AW-1:0] + AW'(9);
      default: ram_raddr = rnd_r[AW-1:0];
    endcase
  end

  // Next placed byte completes the block
  assign place_wrap = (cnt_r == 6'd63);

  // Controller and datapath next state
  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    ph_nxt        = ph_r;
    rnd_nxt       = rnd_r;
    cnt_nxt       = cnt_r;
    len_nxt       = len_r;
    asm_nxt       = asm_r;
    pad_first_nxt = pad_first_r;
    idx_nxt       = idx_r;
    chain_nxt     = chain_r;
    rv_nxt        = rv_r;
    wa_nxt        = wa_r;
    wb_nxt        = wb_r;
    wr_nxt        = wr_r;
    wm1_nxt       = wm1_r;
    wm2_nxt       = wm2_r;
    place_en      = 1'b0;
    place_val     = in_data.data_byte;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[5:2];
    ram_wdata     = 32'd0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          place_en = in_data.has_byte;
          if (in_data.has_byte) begin
            len_nxt = len_r + 64'd8;
          end
          if (in_data.end_of_message) begin
            pad_first_nxt = 1'b1;
            state_nxt     = S_PAD;
          end
          if (in_data.has_byte && place_wrap) begin
            ret_nxt   = in_data.end_of_message ? S_PAD : S_IDLE;
            state_nxt = S_COMP;
          end
        end
      end
      S_PAD: begin
        if (!pad_first_r && cnt_r == LEN_POS) begin
          state_nxt = S_LEN0;
        end else begin
          place_en      = 1'b1;
          place_val     = pad_first_r ? PAD_BYTE : 8'h00;
          pad_first_nxt = 1'b0;
          if (place_wrap) begin
            ret_nxt   = S_PAD;
            state_nxt = S_COMP;
          end
        end
      end
      S_LEN0: begin
        ram_we    = 1'b1;
        ram_waddr = LEN_HI_ADDR;
        ram_wdata = len_r[63:32];
        state_nxt = S_LEN1;
      end
      S_LEN1: begin
        ram_we    = 1'b1;
        ram_waddr = LEN_LO_ADDR;
        ram_wdata = len_r[31:0];
        ret_nxt   = S_OUT;
        state_nxt = S_COMP;
      end
      S_COMP: begin
        unique case (ph_r)
          PH_A: ph_nxt = PH_B;
          PH_B: begin
            wa_nxt = ram_rdata;
            ph_nxt = PH_C;
          end
          PH_C: begin
            wb_nxt = ram_rdata;
            ph_nxt = PH_W;
          end
          PH_W: begin
            // First 16 rounds use the block words as loaded
            if (rnd_r[5:4] == 2'd0) begin
              wr_nxt = wa_r;
            end else begin
              wr_nxt    = sched_sum;
              ram_we    = 1'b1;
              ram_waddr = rnd_r[AW-1:0];
              ram_wdata = sched_sum;
            end
            ph_nxt = PH_RND;
          end
          PH_RND: begin
            rv_nxt[7] = rv_r[6];
            rv_nxt[6] = rv_r[5];
            rv_nxt[5] = rv_r[4];
            rv_nxt[4] = rv_r[3] + t1;
            rv_nxt[3] = rv_r[2];
            rv_nxt[2] = rv_r[1];
            rv_nxt[1] = rv_r[0];
            rv_nxt[0] = t1 + t2;
            wm2_nxt   = wm1_r;
            wm1_nxt   = wr_r;
            rnd_nxt   = rnd_r + 6'd1;
            ph_nxt    = PH_A;
            if (rnd_r == 6'd63) begin
              state_nxt = S_FIN;
            end
          end
          default: ph_nxt = PH_A;
        endcase
      end
      S_FIN: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + rv_r[i];
        end
        idx_nxt   = 2'd0;
        state_nxt = ret_r;
      end
      S_OUT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 2'd1;
          if (idx_r == 2'd3) begin
            chain_nxt = INIT_H;
            cnt_nxt   = 6'd0;
            len_nxt   = 64'd0;
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Byte placement: gather big-endian, write a word on its fourth byte
    if (place_en) begin
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r[1:0] == 2'd3) begin
        ram_we    = 1'b1;
        ram_wdata = {asm_r, place_val};
      end else begin
        asm_nxt = {asm_r[15:0], place_val};
      end
    end

    // Starting a compression loads the working variables
    if (state_nxt == S_COMP && state_r != S_COMP) begin
      rv_nxt  = chain_r;
      rnd_nxt = 6'd0;
      ph_nxt  = PH_A;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      ph_r        <= PH_A;
      rnd_r       <= 6'd0;
      cnt_r       <= 6'd0;
      len_r       <= 64'd0;
      pad_first_r <= 1'b0;
      idx_r       <= 2'd0;
      chain_r     <= INIT_H;
      rv_r        <= '{default: 32'd0};
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      ph_r        <= ph_nxt;
      rnd_r       <= rnd_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      pad_first_r <= pad_first_nxt;
      idx_r       <= idx_nxt;
      chain_r     <= chain_nxt;
      rv_r        <= rv_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    asm_r <= asm_nxt;
    wa_r  <= wa_nxt;
    wb_r  <= wb_nxt;
    wr_r  <= wr_nxt;
    wm1_r <= wm1_nxt;
    wm2_r <= wm2_nxt;
  end

endmodule

@@ hw/rtl/sha256_checker.sv @@
module sha256_checker
  import sha256_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No input taken while a digest is being delivered
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during digest output");

  // Last flag marks exactly the fourth word
  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_word == (out_data.word_index == 2'd3)))
    else $error("last_word mismatch");

  // Digest words come back to back, each with a new index
  a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last_word |=>
      out_valid && (out_data.word_index != $past(out_data.word_index)))
    else $error("digest word sequence broken");

  // Reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sha256_message_digest sha256_checker u_chk (.*);
